FILE: design/assert_macros.svh
// assertion helpers used by the checker file mexp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, held off during reset
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// implication into the next cycle, held off during reset
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    // port width of every data field
    localparam int DATA_W = 64;

    // width of the arithmetic, low bits of each field are used
    localparam int WIDTH = 64;

    // bit counter of one modular multiplication
    localparam int CNT_W = $clog2(WIDTH);

    // operand choice for a multiplication
    typedef enum logic
    {
        SEL_RES,
        SEL_SQR
    } mul_sel_t;

    // commands from the controller to the datapath
    typedef struct packed
    {
        logic     load;
        logic     mul_setup;
        mul_sel_t mul_sel;
        logic     mul_step;
        logic     wb_base;
        logic     wb_res;
        logic     exp_shift;
        logic     emit;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed
    {
        logic m_zero;
        logic e_zero;
        logic e_lsb;
        logic e_next_zero;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: design/mexp_dp.sv
`default_nettype none

module mexp_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mexp_pkg::DATA_W-1:0]   cfg_wr_data,
    input  wire logic [mexp_pkg::DATA_W-1:0]   base_value,
    input  wire logic [mexp_pkg::DATA_W-1:0]   exponent,
    input  wire mexp_pkg::dp_cmd_t             cmd,
    output mexp_pkg::dp_sts_t                  sts,
    output logic      [mexp_pkg::DATA_W-1:0]   power_result,
    output logic                               modulus_zero_error
);

    localparam int W = mexp_pkg::WIDTH;

    logic [W-1:0] modulus_reg;
    logic [W-1:0] acc_reg,      acc_next;
    logic [W-1:0] mcand_reg,    mcand_next;
    logic [W-1:0] mplier_reg,   mplier_next;
    logic [W-1:0] base_reg,     base_next;
    logic [W-1:0] res_reg,      res_next;
    logic [W-1:0] exp_reg,      exp_next;
    logic         err_reg,      err_next;
    logic [W-1:0] out_res_reg,  out_res_next;
    logic         out_err_reg,  out_err_next;

    logic [W+1:0] sum;
    logic [W+1:0] mod1;
    logic [W+1:0] mod2;
    logic [W-1:0] step_val;
    logic [W-1:0] in_base;
    logic [W-1:0] in_exp;

    assign in_base = base_value[W-1:0];
    assign in_exp  = exponent[W-1:0];
    assign mod1    = {2'b00, modulus_reg};
    assign mod2    = {1'b0, modulus_reg, 1'b0};

    // one double-and-add step, the sum stays below three times the modulus
    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0}
            + (mplier_reg[W-1] ? {2'b00, mcand_reg} : {(W+2){1'b0}});
        if (sum >= mod2)
        begin
            step_val = W'(sum - mod2);
        end
        else if (sum >= mod1)
        begin
            step_val = W'(sum - mod1);
        end
        else
        begin
            step_val = sum[W-1:0];
        end
    end

    // status for the controller
    assign sts.m_zero      = (modulus_reg == '0);
    assign sts.e_zero      = (exp_reg == '0);
    assign sts.e_lsb       = exp_reg[0];
    assign sts.e_next_zero = (exp_reg[W-1:1] == '0);

    // next values of the working registers
    always_comb
    begin
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        base_next    = base_reg;
        res_next     = res_reg;
        exp_next     = exp_reg;
        err_next     = err_reg;
        out_res_next = out_res_reg;
        out_err_next = out_err_reg;

        // multiplication step
        if (cmd.mul_step)
        begin
            acc_next    = step_val;
            mplier_next = {mplier_reg[W-2:0], 1'b0};
        end

        // results of a finished multiplication
        if (cmd.wb_base)
        begin
            base_next = step_val;
        end
        if (cmd.wb_res)
        begin
            res_next = step_val;
        end
        if (cmd.exp_shift)
        begin
            exp_next = {1'b0, exp_reg[W-1:1]};
        end

        // operands for the next multiplication
        if (cmd.mul_setup)
        begin
            acc_next = '0;
            unique case (cmd.mul_sel)
                mexp_pkg::SEL_RES:
                begin
                    mcand_next  = res_reg;
                    mplier_next = base_reg;
                end
                mexp_pkg::SEL_SQR:
                begin
                    mcand_next  = base_reg;
                    mplier_next = base_reg;
                end
                default:
                begin
                    mcand_next  = base_reg;
                    mplier_next = base_reg;
                end
            endcase
        end

        // new transaction, base reduction runs as a product with one
        if (cmd.load)
        begin
            acc_next    = '0;
            mcand_next  = W'(1);
            mplier_next = in_base;
            exp_next    = in_exp;
            err_next    = sts.m_zero;
            if (sts.m_zero || (modulus_reg == W'(1) && in_exp != '0))
            begin
                res_next = '0;
            end
            else
            begin
                res_next = W'(1);
            end
        end

        // output payload
        if (cmd.emit)
        begin
            out_res_next = res_reg;
            out_err_next = err_reg;
        end
    end

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            modulus_reg <= cfg_wr_data[W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        base_reg    <= base_next;
        res_reg     <= res_next;
        exp_reg     <= exp_next;
        err_reg     <= err_next;
        out_res_reg <= out_res_next;
        out_err_reg <= out_err_next;
    end

    assign power_result       = mexp_pkg::DATA_W'(out_res_reg);
    assign modulus_zero_error = out_err_reg;

endmodule

`default_nettype wire

FILE: design/mexp_ctrl.sv
`default_nettype none

module mexp_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output mexp_pkg::dp_cmd_t       cmd,
    input  wire mexp_pkg::dp_sts_t  sts
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_REDUCE,
        ST_EXP,
        ST_MUL_RES,
        ST_MUL_SQR,
        ST_FINISH
    } state_t;

    localparam int CW = mexp_pkg::CNT_W;

    state_t          state_reg, state_next;
    logic   [CW-1:0] cnt_reg,   cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            cnt_last;
    logic            out_free;

    assign cnt_last  = (cnt_reg == CW'(mexp_pkg::WIDTH - 1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // sequencing and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = mexp_pkg::SEL_SQR;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = sts.m_zero ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_last)
                begin
                    cmd.wb_base = 1'b1;
                    state_next  = ST_EXP;
                end
            end
            ST_EXP:
            begin
                cnt_next = '0;
                if (sts.e_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.e_lsb)
                begin
                    cmd.mul_setup = 1'b1;
                    cmd.mul_sel   = mexp_pkg::SEL_RES;
                    state_next    = ST_MUL_RES;
                end
                else
                begin
                    cmd.mul_setup = 1'b1;
                    state_next    = ST_MUL_SQR;
                end
            end
            ST_MUL_RES:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_last)
                begin
                    cmd.wb_res = 1'b1;
                    // last exponent bit needs no further squaring
                    if (sts.e_next_zero)
                    begin
                        cmd.exp_shift = 1'b1;
                        state_next    = ST_EXP;
                    end
                    else
                    begin
                        cmd.mul_setup = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_MUL_SQR;
                    end
                end
            end
            ST_MUL_SQR:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_last)
                begin
                    cmd.wb_base   = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_EXP;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/modular_exponentiation.sv
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------
// input    | in_valid / in_stall    | base_value, exponent
// output   | out_valid / out_stall  | power_result, modulus_zero_error
// config   | cfg_wr_en              | cfg_wr_data (modulus)
//
// one transaction at a time; every modular product runs in the shared
// double-and-add unit; acceptance to out_valid covers the base reduction,
// then one product per exponent bit up to the highest set one and a second
// one for each set bit below it; a zero modulus runs no product at all;
// rst_n clears control state and the modulus; the result register lets a
// new transaction in while the last one waits
`default_nettype none

module modular_exponentiation
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [mexp_pkg::DATA_W-1:0]  cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [mexp_pkg::DATA_W-1:0]  base_value,
    input  wire logic [mexp_pkg::DATA_W-1:0]  exponent,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [mexp_pkg::DATA_W-1:0]  power_result,
    output logic                              modulus_zero_error
);

    mexp_pkg::dp_cmd_t cmd;
    mexp_pkg::dp_sts_t sts;

    // sequencer
    mexp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic and registers
    mexp_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .base_value         (base_value),
        .exponent           (exponent),
        .cmd                (cmd),
        .sts                (sts),
        .power_result       (power_result),
        .modulus_zero_error (modulus_zero_error)
    );

endmodule

`default_nettype wire

FILE: design/mexp_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mexp_checker
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [mexp_pkg::DATA_W-1:0]  power_result,
    input wire logic                         modulus_zero_error
);

    // a stalled result stays offered
    `MEXP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // an accepted transaction keeps the input closed for the next cycle
    `MEXP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // a zero modulus forces a zero result
    `MEXP_ASSERT_IMP(a_zero_mod, clk, rst_n, out_valid && modulus_zero_error, power_result == '0)

    // a result right after a taken one comes only with the sequencer back at idle
    `MEXP_ASSERT_NXT(a_back_to_back_out, clk, rst_n, out_valid && !out_stall, !out_valid || !in_stall)

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = mexp_pkg::DATA_W;
    localparam logic [DW-1:0] VAL_MASK = {DW{1'b1}} >> (DW - mexp_pkg::WIDTH);
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};
    localparam logic [DW-1:0] TOP_BIT = {1'b1, {(DW - 1){1'b0}}};
    // largest prime below 2^64
    localparam logic [DW-1:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam int QUIET_LIMIT = 40000;
    localparam int DRAIN_PAD = 200;

    // one input transaction
    typedef struct packed
    {
        logic [DW-1:0] base;
        logic [DW-1:0] exp;
    } op_t;

    // one result transaction
    typedef struct packed
    {
        logic [DW-1:0] value;
        logic          zero_err;
    } power_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [DW-1:0] cfg_wr_data = '0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [DW-1:0] base_value = '0;
    logic [DW-1:0] exponent = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [DW-1:0] power_result;
    logic          modulus_zero_error;

    op_t           pending_ops[$];
    power_t        expected_powers[$];
    logic [DW-1:0] modulus_copy = '0;
    op_t           next_op;
    logic          in_taken = 1'b0;
    logic          calm = 1'b0;
    int            in_gap_left = 0;
    int            stall_left = 0;
    int            items_queued = 0;
    int            results_seen = 0;
    int            fail_count = 0;
    int            quiet_cycles = 0;
    int            modulus_settings = 1;
    int            wide_exp_count = 0;

    modular_exponentiation u_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .base_value         (base_value),
        .exponent           (exponent),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .power_result       (power_result),
        .modulus_zero_error (modulus_zero_error)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // right-to-left square-and-multiply on exact double-width products
    function automatic power_t predict_power(input logic [DW-1:0] base,
                                             input logic [DW-1:0] exp,
                                             input logic [DW-1:0] modulus);
        power_t          res;
        logic [2*DW-1:0] wide;
        logic [DW-1:0]   b;
        logic [DW-1:0]   e;
        logic [DW-1:0]   m;
        logic [DW-1:0]   r;
        m = modulus & VAL_MASK;
        b = base & VAL_MASK;
        e = exp & VAL_MASK;
        if (m == '0)
        begin
            res.value = '0;
            res.zero_err = 1'b1;
        end
        else
        begin
            b = b % m;
            r = DW'(1);
            while (e != '0)
            begin
                if (e[0])
                begin
                    wide = {{DW{1'b0}}, r} * {{DW{1'b0}}, b};
                    r = DW'(wide % {{DW{1'b0}}, m});
                end
                wide = {{DW{1'b0}}, b} * {{DW{1'b0}}, b};
                b = DW'(wide % {{DW{1'b0}}, m});
                e = e >> 1;
            end
            res.value = r & VAL_MASK;
            res.zero_err = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly short exponents, now and then a zero or a full-width one
    function automatic logic [DW-1:0] pick_exponent();
        logic [DW-1:0] e;
        int            bits;
        e = rand_word();
        case ($urandom_range(0, 19))
            0: e = e | TOP_BIT;
            1: e = '0;
            2: e = e >> $urandom_range(0, DW - 1);
            default:
            begin
                bits = $urandom_range(1, 16);
                e = e >> (DW - bits);
            end
        endcase
        return e;
    endfunction

    function automatic logic [DW-1:0] pick_base(input logic [DW-1:0] m);
        logic [DW-1:0] b;
        case ($urandom_range(0, 9))
            0: b = '0;
            1: b = ALL_ONES;
            2: b = m - 1;
            3: b = m;
            4: b = DW'($urandom_range(1, 20));
            default: b = rand_word();
        endcase
        return b;
    endfunction

    task automatic push_op(input logic [DW-1:0] base, input logic [DW-1:0] exp);
        op_t op;
        op.base = base;
        op.exp = exp;
        pending_ops.push_back(op);
        items_queued++;
        if (exp[DW-1])
            wide_exp_count++;
    endtask

    // every queued transaction has produced its result
    task automatic wait_drained();
        while (results_seen != items_queued)
            @(negedge clk);
    endtask

    task automatic write_modulus(input logic [DW-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        modulus_settings++;
    endtask

    // one modulus setting with random content, optionally drained halfway
    task automatic run_random_phase(input logic [DW-1:0] m, input int count,
                                    input logic hold_mid);
        write_modulus(m);
        for (int i = 0; i < count; i++)
        begin
            if (hold_mid && i == count / 2)
                wait_drained();
            push_op(pick_base(m), pick_exponent());
        end
        wait_drained();
    endtask

    // input driver: holds a stalled transaction, inserts idle bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (in_gap_left > 0)
            begin
                in_gap_left = in_gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() == 0)
                in_valid <= 1'b0;
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                in_gap_left = $urandom_range(0, 6);
                in_valid <= 1'b0;
            end
            else
            begin
                next_op = pending_ops.pop_front();
                base_value <= next_op.base;
                exponent <= next_op.exp;
                in_valid <= 1'b1;
            end
        end
    end

    // output backpressure in bursts
    always @(negedge clk)
    begin
        if (calm || !rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin : monitor_proc
        power_t want;
        if (!rst_n)
            in_taken = 1'b0;
        else
        begin
            if (cfg_wr_en)
                modulus_copy = cfg_wr_data & VAL_MASK;
            in_taken = in_valid && !in_stall;
            if (in_taken)
                expected_powers.push_back(predict_power(base_value, exponent, modulus_copy));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_powers.size() == 0)
                begin
                    $error("unexpected result: power_result %h, modulus_zero_error %b",
                           power_result, modulus_zero_error);
                    fail_count++;
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (power_result !== want.value)
                    begin
                        $error("power_result mismatch: expected %h, actual %h",
                               want.value, power_result);
                        fail_count++;
                    end
                    if (modulus_zero_error !== want.zero_err)
                    begin
                        $error("modulus_zero_error mismatch: expected %b, actual %b",
                               want.zero_err, modulus_zero_error);
                        fail_count++;
                    end
                end
            end
            if (in_taken || (out_valid && !out_stall) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog on cycles without any transaction
    always @(negedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: timeout after %0d cycles without a transaction", quiet_cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // modulus still at its reset value of zero
        push_op(64'd5, 64'd3);
        push_op(ALL_ONES, ALL_ONES);
        push_op('0, '0);
        wait_drained();

        // modulus of one: zero exponent still gives one
        write_modulus(64'd1);
        push_op(64'd7, '0);
        push_op(64'd7, 64'd5);
        push_op('0, 64'd1);
        wait_drained();

        // largest modulus, extreme operands
        write_modulus(ALL_ONES);
        push_op('0, '0);
        push_op(ALL_ONES, 64'd1);
        push_op(ALL_ONES - 1, 64'd2);
        push_op(64'd2, ALL_ONES);
        push_op('0, 64'd5);
        push_op(64'd3, TOP_BIT);
        wait_drained();

        // prime modulus above 2^32, Fermat and wraparound cases
        write_modulus(BIG_PRIME);
        push_op(64'd2, BIG_PRIME - 1);
        push_op(rand_word(), 64'd1);
        push_op(64'd1, rand_word());
        push_op(BIG_PRIME - 1, 64'd2);
        push_op(ALL_ONES, 64'd3);
        wait_drained();

        // tiny modulus
        write_modulus(64'd2);
        push_op(64'd3, 64'd10);
        push_op(64'd4, 64'd7);
        wait_drained();

        // random part over several moduli
        run_random_phase(rand_word() | TOP_BIT, 16, 1'b1);
        run_random_phase({32'd0, $urandom} | 64'd1, 16, 1'b0);
        run_random_phase(DW'($urandom_range(2, 1000)), 16, 1'b0);
        run_random_phase('0, 8, 1'b0);
        run_random_phase({32'd1, $urandom}, 16, 1'b0);
        calm = 1'b1;
        run_random_phase(rand_word(), 16, 1'b0);

        // let any stray result show up
        repeat (DRAIN_PAD) @(negedge clk);
        if (expected_powers.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_powers.size());
            fail_count++;
        end

        $display("tb: %0d transactions checked over %0d modulus settings",
                 results_seen, modulus_settings);
        $display("tb: %0d of them carried a full-width exponent", wide_exp_count);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
